/* rtl/plucked_string_synth_voice_macros.svh */
// Assertion macros shared by the voice RTL.
// Each macro takes a label, the clock, the reset, an antecedent and a consequent.
`ifndef PLUCKED_STRING_SYNTH_VOICE_MACROS_SVH
`define PLUCKED_STRING_SYNTH_VOICE_MACROS_SVH
`ifndef NO_ASSERTIONS
`define PSSV_ASSERT_IMP(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("pssv assertion failed");
`define PSSV_ASSERT_NXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("pssv assertion failed");
`else
`define PSSV_ASSERT_IMP(label, clk, rst, ante, cons)
`define PSSV_ASSERT_NXT(label, clk, rst, ante, cons)
`endif
`endif

/* rtl/pssv_pkg.sv */
`default_nettype none
package pssv_pkg;

   localparam int RING_DEPTH_DEF = 2048;
   localparam int SINE_SIZE_DEF  = 256;

   localparam int DELAY_W    = 11;
   localparam int DELAY_MAX  = 2047;
   localparam int PHASE_W    = 16;
   localparam int GAIN_W     = 17;
   localparam int SAMPLE_W   = 16;
   localparam int CSR_INDEX_W = 3;
   localparam int CSR_DATA_W  = 17;

   localparam int RECIP_D_SH = 24;
   localparam int RECIP_S_SH = 28;

   localparam logic [CSR_INDEX_W-1:0] CSR_FEEDBACK_GAIN   = 3'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_DELAY_LENGTH    = 3'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_LOWPASS_COEFF   = 3'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_BURST_SHAPE     = 3'd3;
   localparam logic [CSR_INDEX_W-1:0] CSR_BURST_DECREMENT = 3'd4;
   localparam logic [CSR_INDEX_W-1:0] CSR_PHASE_STEP      = 3'd5;

   localparam logic [2:0] SHAPE_NOISE    = 3'd0;
   localparam logic [2:0] SHAPE_SINE     = 3'd1;
   localparam logic [2:0] SHAPE_TRIANGLE = 3'd2;
   localparam logic [2:0] SHAPE_SQUARE   = 3'd3;
   localparam logic [2:0] SHAPE_SAW      = 3'd4;

   localparam logic [GAIN_W-1:0] GAIN_ONE  = 17'd65536;
   localparam logic [31:0]       LFSR_SEED = 32'h0000_ACE1;
   localparam logic [31:0]       LFSR_MASK = 32'h8020_0003;
   localparam logic [15:0]       SINE_K0   = 16'd50790;
   localparam logic [15:0]       SINE_K1   = 16'd14746;

   typedef struct packed {
      logic [15:0]        feedback_gain;
      logic [DELAY_W-1:0] delay_length;
      logic [15:0]        lowpass_coeff;
      logic [2:0]         burst_shape;
      logic [GAIN_W-1:0]  burst_decrement;
      logic [PHASE_W-1:0] phase_step;
   } cfg_type;

   localparam cfg_type CFG_RESET = '{
      feedback_gain:   16'd64881,
      delay_length:    11'd240,
      lowpass_coeff:   16'd21500,
      burst_shape:     SHAPE_NOISE,
      burst_decrement: 17'd137,
      phase_step:      16'd1092
   };

   typedef struct packed {
      logic start;
      logic quant;
      logic recip;
      logic fix;
      logic poly_a;
      logic poly_b;
      logic poly_c;
      logic scale;
      logic commit;
   } dp_cmd_type;

endpackage
`default_nettype wire

/* rtl/pssv_if.sv */
`default_nettype none
interface pssv_req_if;
   logic valid;
   logic ready;
   logic pluck;

   modport source (output valid, output pluck, input ready);
   modport sink   (input valid, input pluck, output ready);
endinterface

interface pssv_rsp_if;
   logic               valid;
   logic               ready;
   logic signed [15:0] sample_out;

   modport source (output valid, output sample_out, input ready);
   modport sink   (input valid, input sample_out, output ready);
endinterface
`default_nettype wire

/* rtl/plucked_string_synth_voice.sv */
// Plucked-string voice: one output sample for every input tick.
// Input channel req_ch carries one tick per transfer; pluck restarts the
// excitation burst at full scale before that sample is computed.
// Output channel rsp_ch carries the delayed string sample, signed Q1.15,
// one transfer for every input transfer, in order.
// Configuration is written through csr_wr_en, csr_index and csr_wdata; the
// user must write it only while the voice is idle, as the block does not
// enforce it; unknown indexes are ignored. An accepted tick is worked through
// eight sequencer steps, each with its own narrow multiply or compare stage;
// a new tick is accepted only after the previous one has finished its final
// step and the voice is back in idle.
// The output register holds one finished sample; the next tick is already
// accepted and worked on while it waits, and its final step stalls until
// the receiver takes the sample.
// Reset clears the write pointer, the lowpass state, the burst gain and the
// phase, seeds the noise generator and restores the register defaults. The
// ring needs no clearing pass: entries not yet written since reset read as
// zero until the write pointer first wraps.
`default_nettype none
module plucked_string_synth_voice
   import pssv_pkg::*;
#(
   parameter int RING_DEPTH      = RING_DEPTH_DEF,
   parameter int SINE_TABLE_SIZE = SINE_SIZE_DEF
)
(
   input  logic                   clock,
   input  logic                   reset,
   pssv_req_if.sink               req_ch,
   pssv_rsp_if.source             rsp_ch,
   input  logic                   csr_wr_en,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_wdata
);

   cfg_type                    cfg;
   dp_cmd_type                 cmd;
   logic                       req_ready;
   logic                       rsp_valid;
   logic signed [SAMPLE_W-1:0] sample;

   pssv_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_wr_en (csr_wr_en),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   pssv_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_ch.valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ch.ready),
      .cmd       (cmd)
   );

   pssv_dp #(
      .RING_DEPTH      (RING_DEPTH),
      .SINE_TABLE_SIZE (SINE_TABLE_SIZE)
   ) u_dp (
      .clock      (clock),
      .reset      (reset),
      .cfg        (cfg),
      .pluck      (req_ch.pluck),
      .cmd        (cmd),
      .sample_out (sample)
   );

   assign req_ch.ready      = req_ready;
   assign rsp_ch.valid      = rsp_valid;
   assign rsp_ch.sample_out = sample;

endmodule
`default_nettype wire

/* rtl/pssv_csr.sv */
`default_nettype none
module pssv_csr
   import pssv_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   csr_wr_en,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_wdata,
   output cfg_type                cfg
);

   cfg_type cfg_ff;
   cfg_type cfg_in;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_wr_en) begin
         case (csr_index)
            CSR_FEEDBACK_GAIN:   cfg_in.feedback_gain   = csr_wdata[15:0];
            CSR_DELAY_LENGTH:    cfg_in.delay_length    = csr_wdata[DELAY_W-1:0];
            CSR_LOWPASS_COEFF:   cfg_in.lowpass_coeff   = csr_wdata[15:0];
            CSR_BURST_SHAPE:     cfg_in.burst_shape     = csr_wdata[2:0];
            CSR_BURST_DECREMENT: cfg_in.burst_decrement = csr_wdata[GAIN_W-1:0];
            CSR_PHASE_STEP:      cfg_in.phase_step      = csr_wdata[PHASE_W-1:0];
            default:             cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= CFG_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule
`default_nettype wire

/* rtl/pssv_ctrl.sv */
`default_nettype none
`include "plucked_string_synth_voice_macros.svh"
module pssv_ctrl
   import pssv_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   output dp_cmd_type cmd
);

   localparam logic [3:0] ST_IDLE   = 4'd0;
   localparam logic [3:0] ST_QUANT  = 4'd1;
   localparam logic [3:0] ST_RECIP  = 4'd2;
   localparam logic [3:0] ST_FIX    = 4'd3;
   localparam logic [3:0] ST_POLY_A = 4'd4;
   localparam logic [3:0] ST_POLY_B = 4'd5;
   localparam logic [3:0] ST_POLY_C = 4'd6;
   localparam logic [3:0] ST_SCALE  = 4'd7;
   localparam logic [3:0] ST_COMMIT = 4'd8;

   logic [3:0] state_ff;
   logic [3:0] state_in;
   logic       rsp_valid_ff;
   logic       rsp_valid_in;
   logic       out_free;
   logic       accept;

   assign req_ready = (state_ff == ST_IDLE);
   assign accept    = req_valid && req_ready;
   assign out_free  = !rsp_valid_ff || rsp_ready;

   always_comb begin
      cmd        = '0;
      cmd.start  = accept;
      cmd.quant  = (state_ff == ST_QUANT);
      cmd.recip  = (state_ff == ST_RECIP);
      cmd.fix    = (state_ff == ST_FIX);
      cmd.poly_a = (state_ff == ST_POLY_A);
      cmd.poly_b = (state_ff == ST_POLY_B);
      cmd.poly_c = (state_ff == ST_POLY_C);
      cmd.scale  = (state_ff == ST_SCALE);
      cmd.commit = (state_ff == ST_COMMIT) && out_free;
   end

   always_comb begin
      case (state_ff)
         ST_IDLE:   state_in = accept ? ST_QUANT : ST_IDLE;
         ST_QUANT:  state_in = ST_RECIP;
         ST_RECIP:  state_in = ST_FIX;
         ST_FIX:    state_in = ST_POLY_A;
         ST_POLY_A: state_in = ST_POLY_B;
         ST_POLY_B: state_in = ST_POLY_C;
         ST_POLY_C: state_in = ST_SCALE;
         ST_SCALE:  state_in = ST_COMMIT;
         ST_COMMIT: state_in = out_free ? ST_IDLE : ST_COMMIT;
         default:   state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      if (cmd.commit) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;

   `PSSV_ASSERT_NXT(a_accept_starts, clock, reset, accept, state_ff == ST_QUANT)
   `PSSV_ASSERT_NXT(a_commit_shows, clock, reset, cmd.commit, rsp_valid_ff && req_ready)
   `PSSV_ASSERT_NXT(a_stall_holds, clock, reset, rsp_valid_ff && !rsp_ready, rsp_valid_ff)

endmodule
`default_nettype wire

/* rtl/pssv_dp.sv */
`default_nettype none
`include "plucked_string_synth_voice_macros.svh"
module pssv_dp
   import pssv_pkg::*;
#(
   parameter int RING_DEPTH      = RING_DEPTH_DEF,
   parameter int SINE_TABLE_SIZE = SINE_SIZE_DEF
)
(
   input  logic                       clock,
   input  logic                       reset,
   input  cfg_type                    cfg,
   input  logic                       pluck,
   input  dp_cmd_type                 cmd,
   output logic signed [SAMPLE_W-1:0] sample_out
);

   localparam int AW      = $clog2(RING_DEPTH);
   localparam int DQW     = $clog2(DELAY_MAX / RING_DEPTH + 2);
   localparam int RECIP_D = (1 << RECIP_D_SH) / RING_DEPTH;
   localparam int RDW     = $clog2(RECIP_D + 1);
   localparam int DPW     = (RECIP_D_SH + DQW > DELAY_W + RDW) ? RECIP_D_SH + DQW
                                                               : DELAY_W + RDW;
   localparam int DMW     = DQW + AW + 1;
   localparam int QW      = $clog2(SINE_TABLE_SIZE);
   localparam int SW      = $clog2(SINE_TABLE_SIZE + 1);
   localparam int RECIP_S = (1 << RECIP_S_SH) / SINE_TABLE_SIZE;
   localparam int RSW     = $clog2(RECIP_S + 1);
   localparam int EPW     = (RECIP_S_SH > QW + RSW) ? RECIP_S_SH : QW + RSW;
   localparam int FW      = QW + PHASE_W + 1;

   function automatic logic [31:0] lfsr_step8(input logic [31:0] v);
      logic [31:0] r;
      r = v;
      for (int k = 0; k < 8; k++) begin
         r = r[0] ? ((r >> 1) ^ LFSR_MASK) : (r >> 1);
      end
      return r;
   endfunction

   logic signed [SAMPLE_W-1:0] ring_mem [RING_DEPTH];

   logic [GAIN_W-1:0]          gain_ff, gain_in;
   logic [PHASE_W-1:0]         phase_ff, phase_in;
   logic [31:0]                lfsr_ff, lfsr_in;
   logic signed [SAMPLE_W-1:0] mem_ff, mem_in;
   logic [AW-1:0]              wi_ff, wi_in;
   logic                       wrapped_ff, wrapped_in;

   logic [QW-1:0]              q_ff;
   logic [PHASE_W-1:0]         est_ff, qp_ff;
   logic [16:0]                s_ff, t_ff;
   logic signed [16:0]         wsin_ff;
   logic [DQW-1:0]             dq_ff;
   logic [DMW-1:0]             dr_ff;
   logic [AW-1:0]              dmod_ff, rd_ff;
   logic                       rd_valid_ff;
   logic signed [SAMPLE_W-1:0] rd_data_ff, delayed_ff, sample_ff;
   logic signed [16:0]         exc_ff, loop_ff;

   logic                       active, noise_on;
   logic [DELAY_W-1:0]         dsel;
   logic [PHASE_W+SW-1:0]      qprod;
   logic [EPW-1:0]             eprod;
   logic [FW-1:0]              fprod, frem;
   logic [PHASE_W-1:0]         qp_in, est_in, x;
   logic [16:0]                omx, s_in, t_in, v;
   logic [33:0]                sprod, rprod;
   logic [31:0]                tprod;
   logic signed [16:0]         wsin_in;
   logic [DPW-1:0]             dprod;
   logic [DMW-1:0]             dmul, dr_in;
   logic [AW-1:0]              dmod_in, rd_in;
   logic [AW:0]                rd_wide, wi_wide;
   logic                       rd_valid_in;
   logic signed [SAMPLE_W-1:0] delayed;
   logic signed [16:0]         diff;
   logic signed [33:0]         lprod;
   logic signed [SAMPLE_W-1:0] filtered;
   logic signed [32:0]         oprod;
   logic [17:0]                pd;
   logic signed [17:0]         tri_w;
   logic signed [16:0]         wave;
   logic signed [34:0]         xprod;
   logic signed [17:0]         sum;
   logic signed [SAMPLE_W-1:0] sat;

   assign active   = (gain_ff != '0);
   assign noise_on = active && (cfg.burst_shape == SHAPE_NOISE);
   assign dsel     = (cfg.delay_length == '0) ? DELAY_W'(1) : cfg.delay_length;

   // Phase quantisation: q = p*N/65536, then q*65536/N by reciprocal and one correction.
   assign qprod  = (PHASE_W+SW)'(phase_ff) * (PHASE_W+SW)'(SINE_TABLE_SIZE);
   assign eprod  = EPW'(q_ff) * EPW'(RECIP_S);
   assign est_in = eprod[RECIP_S_SH-PHASE_W +: PHASE_W];
   assign fprod  = FW'(est_ff) * FW'(SINE_TABLE_SIZE);
   assign frem   = {1'b0, q_ff, {PHASE_W{1'b0}}} - fprod;
   assign qp_in  = (frem >= FW'(SINE_TABLE_SIZE)) ? est_ff + 16'd1 : est_ff;

   assign x       = {qp_ff[14:0], 1'b0};
   assign omx     = GAIN_ONE - {1'b0, x};
   assign sprod   = 34'(x) * 34'(omx);
   assign s_in    = sprod[30:14];
   assign tprod   = 32'(SINE_K1) * 32'(s_ff);
   assign t_in    = {1'b0, SINE_K0} + {1'b0, tprod[31:16]};
   assign rprod   = 34'(s_ff) * 34'(t_ff);
   assign v       = rprod[33:17];
   assign wsin_in = qp_ff[15] ? -$signed(v) : $signed(v);

   // Delay reduced modulo the ring depth by reciprocal, then one compare and subtract.
   assign dprod   = DPW'(dsel) * DPW'(RECIP_D);
   assign dmul    = DMW'(dq_ff) * DMW'(RING_DEPTH);
   assign dr_in   = DMW'(dsel) - dmul;
   assign dmod_in = (dr_ff >= DMW'(RING_DEPTH)) ? AW'(dr_ff - DMW'(RING_DEPTH))
                                                : AW'(dr_ff);
   assign wi_wide = {1'b0, wi_ff};
   assign rd_wide = (wi_wide >= {1'b0, dmod_ff})
                    ? wi_wide - {1'b0, dmod_ff}
                    : wi_wide + (AW+1)'(RING_DEPTH) - {1'b0, dmod_ff};
   assign rd_in   = rd_wide[AW-1:0];
   // Entries at or beyond the write pointer are unwritten until the first wrap and read as zero.
   assign rd_valid_in = wrapped_ff || (rd_in < wi_ff);

   assign delayed  = rd_valid_ff ? rd_data_ff : '0;
   assign diff     = {delayed[15], delayed} - {mem_ff[15], mem_ff};
   assign lprod    = $signed({1'b0, cfg.lowpass_coeff}) * diff;
   assign filtered = mem_ff + $signed(lprod[31:16]);
   assign oprod    = mem_ff * $signed({1'b0, cfg.feedback_gain});

   assign pd    = {1'b0, phase_ff, 1'b0};
   assign tri_w = phase_ff[15] ? 18'sd98304 - $signed(pd) : $signed(pd) - 18'sd32768;

   always_comb begin
      case (cfg.burst_shape)
         SHAPE_NOISE:    wave = $signed({~lfsr_ff[15], ~lfsr_ff[15], lfsr_ff[14:0]});
         SHAPE_SINE:     wave = wsin_ff;
         SHAPE_TRIANGLE: wave = tri_w[16:0];
         SHAPE_SQUARE:   wave = qp_ff[15] ? -17'sd32768 : 17'sd32768;
         SHAPE_SAW:      wave = $signed({phase_ff[15], phase_ff});
         default:        wave = '0;
      endcase
   end

   assign xprod = wave * $signed({1'b0, gain_ff});
   assign sum   = {exc_ff[16], exc_ff} + {loop_ff[16], loop_ff};

   always_comb begin
      if (sum > 18'sd32767) begin
         sat = 16'sh7FFF;
      end else if (sum < -18'sd32768) begin
         sat = 16'sh8000;
      end else begin
         sat = sum[15:0];
      end
   end

   always_comb begin
      gain_in    = gain_ff;
      phase_in   = phase_ff;
      lfsr_in    = lfsr_ff;
      mem_in     = mem_ff;
      wi_in      = wi_ff;
      wrapped_in = wrapped_ff;
      if (cmd.start && pluck) begin
         gain_in = GAIN_ONE;
      end
      if ((cmd.quant || cmd.recip) && noise_on) begin
         lfsr_in = lfsr_step8(lfsr_ff);
      end
      if (cmd.poly_c) begin
         mem_in = filtered;
      end
      if (cmd.commit) begin
         gain_in = (cfg.burst_decrement >= gain_ff) ? '0 : gain_ff - cfg.burst_decrement;
         if (active) begin
            phase_in = phase_ff + cfg.phase_step;
         end
         if (wi_ff == AW'(RING_DEPTH - 1)) begin
            wi_in      = '0;
            wrapped_in = 1'b1;
         end else begin
            wi_in = wi_ff + AW'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         gain_ff    <= '0;
         phase_ff   <= '0;
         lfsr_ff    <= LFSR_SEED;
         mem_ff     <= '0;
         wi_ff      <= '0;
         wrapped_ff <= 1'b0;
      end else begin
         gain_ff    <= gain_in;
         phase_ff   <= phase_in;
         lfsr_ff    <= lfsr_in;
         mem_ff     <= mem_in;
         wi_ff      <= wi_in;
         wrapped_ff <= wrapped_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.quant) begin
         q_ff  <= qprod[PHASE_W +: QW];
         dq_ff <= dprod[RECIP_D_SH +: DQW];
      end
      if (cmd.recip) begin
         est_ff <= est_in;
         dr_ff  <= dr_in;
      end
      if (cmd.fix) begin
         qp_ff   <= qp_in;
         dmod_ff <= dmod_in;
      end
      if (cmd.poly_a) begin
         s_ff        <= s_in;
         rd_ff       <= rd_in;
         rd_valid_ff <= rd_valid_in;
      end
      if (cmd.poly_b) begin
         t_ff <= t_in;
      end
      if (cmd.poly_c) begin
         wsin_ff    <= wsin_in;
         delayed_ff <= delayed;
      end
      if (cmd.scale) begin
         exc_ff  <= xprod[32:16];
         loop_ff <= oprod[32:16];
      end
      if (cmd.commit) begin
         sample_ff <= delayed_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.poly_b) begin
         rd_data_ff <= ring_mem[rd_ff];
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.commit) begin
         ring_mem[wi_ff] <= sat;
      end
   end

   assign sample_out = sample_ff;

   `PSSV_ASSERT_IMP(a_gain_range, clock, reset, 1'b1, gain_ff <= GAIN_ONE)
   `PSSV_ASSERT_IMP(a_wi_range, clock, reset, 1'b1, wi_wide < (AW+1)'(RING_DEPTH))
   `PSSV_ASSERT_NXT(a_sample_hold, clock, reset, !cmd.commit, $stable(sample_ff))

endmodule
`default_nettype wire
